/* rtl/grht_pkg.sv */
package grht_pkg;

  // Table geometry
  localparam int unsigned SLOT_COUNT  = 1024;
  localparam int unsigned SLOT_BITS   = $clog2(SLOT_COUNT);
  localparam int unsigned FILL_BITS   = SLOT_BITS + 1;
  localparam int unsigned INDEX_WIDTH = 20;
  localparam int unsigned HANDLE_BITS = 32;
  localparam int unsigned GEN_BITS    = HANDLE_BITS - INDEX_WIDTH;
  localparam logic [GEN_BITS-1:0] GEN_MAX = '1;

  // Payload and count fields
  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned BINDLESS_BITS = 20;
  localparam int unsigned DIM_BITS      = 16;
  localparam int unsigned PAYLOAD_BITS  = BINDLESS_BITS + 2 * DIM_BITS;

  // Stream widths
  localparam int unsigned KIND_BITS     = 2;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned IN_RAW_BITS   = HANDLE_BITS + PAYLOAD_BITS;
  localparam int unsigned IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_BITS  = HANDLE_BITS + PAYLOAD_BITS + COUNT_BITS + 1;
  localparam int unsigned OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_ATTACH  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // One slot of the table: payload is {height, width, bindless}
  typedef struct packed {
    logic                    live;
    logic [GEN_BITS-1:0]     gen;
    logic [COUNT_BITS-1:0]   count;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_word_t;

  typedef struct packed {
    logic capture;
    logic pop;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic stack_nonempty;
    logic out_busy;
  } dp_sts_t;

endpackage

/* rtl/generational_refcount_handle_table_core.sv */
// A result is registered in the update state that follows the capture of its transaction,
// with a free-stack pop state between them for an allocate that reuses a freed slot, and
// the update waits while the previous result still waits to be taken.  A new operation is
// accepted only in idle, as the slot memory is read-modify-written through one read and one
// write port.  Reset: the state machine, free-stack depth and output valid clear at once and
// the fresh-slot pointer goes to one; no memory clearing pass, so operations are taken straight away.
module generational_refcount_handle_table_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Operation stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: handle_in[31:0], bindless_in[51:32], width_in[67:52],
  // height_in[83:68], zero padding
  input  logic [grht_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [grht_pkg::KIND_BITS-1:0]      s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0: handle_out[31:0], bindless_out[51:32], width_out[67:52],
  // height_out[83:68], ref_count_out[99:84], slot_freed[100], zero padding
  output logic [grht_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // tuser: status[1:0]
  output logic [grht_pkg::STATUS_BITS-1:0]    m_axis_tuser
);

  // The controller sequences each transaction through capture, an optional free-stack
  // pop and the update; the datapath holds the slot memory, the free stack, the fill
  // pointer and the result register.  Slots at or above the fill pointer have never
  // been handed out and are rejected before their memory word is trusted, which is
  // why the memories need no clearing after reset.
  grht_pkg::dp_cmd_t cmd;
  grht_pkg::dp_sts_t sts;

  grht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The result register decouples the two sides: a new transaction may be accepted
  // while the previous result still waits on the master side.
  grht_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata),
    .in_kind_i    (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

/* rtl/grht_ctrl.sv */
module grht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  grht_pkg::dp_sts_t sts_i,
  output grht_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_POP    = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.in_alloc && sts_i.stack_nonempty) begin
            state_d = S_POP;
          end else begin
            state_d = S_UPDATE;
          end
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_UPDATE;
      end
      S_UPDATE: begin
        if (!sts_i.out_busy) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_pop_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> (state_q == S_UPDATE))
    else $error("pop not followed by update");
  a_capture_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (state_q == S_IDLE) && !cmd_o.update && !cmd_o.pop)
    else $error("capture outside idle");
  a_update_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) && sts_i.out_busy |-> !cmd_o.update)
    else $error("update while output busy");
`endif

endmodule

/* rtl/grht_dp.sv */
module grht_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  grht_pkg::dp_cmd_t                    cmd_i,
  output grht_pkg::dp_sts_t                    sts_o,
  input  logic [grht_pkg::IN_DATA_BITS-1:0]    in_data_i,
  input  logic [grht_pkg::KIND_BITS-1:0]       in_kind_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [grht_pkg::OUT_DATA_BITS-1:0]   out_data_o,
  output logic [grht_pkg::STATUS_BITS-1:0]     out_status_o
);

  localparam int unsigned SB = grht_pkg::SLOT_BITS;
  localparam int unsigned FB = grht_pkg::FILL_BITS;
  localparam int unsigned IW = grht_pkg::INDEX_WIDTH;
  localparam int unsigned GB = grht_pkg::GEN_BITS;
  localparam int unsigned CB = grht_pkg::COUNT_BITS;
  localparam int unsigned PB = grht_pkg::PAYLOAD_BITS;
  localparam int unsigned HB = grht_pkg::HANDLE_BITS;

  // Memories
  grht_pkg::slot_word_t slot_mem [grht_pkg::SLOT_COUNT];
  logic [SB-1:0]        fs_mem   [grht_pkg::SLOT_COUNT];

  // Captured item
  grht_pkg::kind_e   kind_q;
  logic [HB-1:0]     handle_q;
  logic [PB-1:0]     payload_q;

  grht_pkg::slot_word_t slot_rd_q;
  logic [SB-1:0]        fs_top_q;

  logic [FB-1:0] depth_q, depth_d;
  logic [FB-1:0] fresh_q, fresh_d;

  // Output register
  logic                    out_valid_q;
  grht_pkg::status_e       out_status_q, out_status_d;
  logic [HB-1:0]           out_handle_q, out_handle_d;
  logic [PB-1:0]           out_payload_q, out_payload_d;
  logic [CB-1:0]           out_count_q, out_count_d;
  logic                    out_freed_q, out_freed_d;

  logic [SB-1:0]        slot_raddr;
  logic [SB-1:0]        fs_raddr;
  logic [FB-1:0]        depth_dec;
  logic                 slot_we;
  logic [SB-1:0]        slot_waddr;
  grht_pkg::slot_word_t slot_wdata;
  logic                 fs_push;

  logic [IW-1:0] h_idx;
  logic [GB-1:0] h_gen;
  logic          h_valid;
  logic [GB-1:0] gen_next;
  logic [CB-1:0] cnt_new;

  assign sts_o.in_alloc       = (grht_pkg::kind_e'(in_kind_i) == grht_pkg::KIND_ALLOC);
  assign sts_o.stack_nonempty = (depth_q != '0);
  assign sts_o.out_busy       = out_valid_q && !out_ready_i;

  assign depth_dec  = depth_q - FB'(1);
  assign fs_raddr   = depth_dec[SB-1:0];
  assign slot_raddr = cmd_i.pop ? fs_top_q : in_data_i[SB-1:0];

  assign h_idx    = handle_q[IW-1:0];
  assign h_gen    = handle_q[HB-1:IW];
  assign h_valid  = (h_idx != '0) && (h_idx < IW'(fresh_q)) && slot_rd_q.live
                    && (slot_rd_q.gen == h_gen);
  assign gen_next = (slot_rd_q.gen == grht_pkg::GEN_MAX) ? GB'(1) : slot_rd_q.gen + GB'(1);

  always_comb begin
    depth_d       = depth_q;
    fresh_d       = fresh_q;
    slot_we       = 1'b0;
    slot_waddr    = h_idx[SB-1:0];
    slot_wdata    = slot_rd_q;
    fs_push       = 1'b0;
    cnt_new       = slot_rd_q.count;
    out_status_d  = grht_pkg::ST_OK;
    out_handle_d  = '0;
    out_payload_d = '0;
    out_count_d   = '0;
    out_freed_d   = 1'b0;
    if (kind_q == grht_pkg::KIND_ALLOC) begin
      slot_wdata.live    = 1'b1;
      slot_wdata.count   = CB'(1);
      slot_wdata.payload = payload_q;
      if (depth_q != '0) begin
        // Reuse the most recently freed slot
        slot_we        = cmd_i.update;
        slot_waddr     = fs_top_q;
        slot_wdata.gen = gen_next;
        depth_d        = depth_dec;
      end else if (fresh_q < FB'(grht_pkg::SLOT_COUNT)) begin
        slot_we        = cmd_i.update;
        slot_waddr     = fresh_q[SB-1:0];
        slot_wdata.gen = GB'(1);
        fresh_d        = fresh_q + FB'(1);
      end else begin
        out_status_d = grht_pkg::ST_FULL;
      end
      if (out_status_d == grht_pkg::ST_OK) begin
        out_handle_d  = {slot_wdata.gen, IW'(slot_waddr)};
        out_payload_d = payload_q;
        out_count_d   = CB'(1);
      end
    end else if (!h_valid) begin
      out_status_d = grht_pkg::ST_INVALID;
    end else begin
      out_payload_d = slot_rd_q.payload;
      case (kind_q)
        grht_pkg::KIND_ATTACH: begin
          if (slot_rd_q.count != '1) begin
            cnt_new = slot_rd_q.count + CB'(1);
          end
        end
        grht_pkg::KIND_RELEASE: begin
          if (slot_rd_q.count != '0) begin
            cnt_new = slot_rd_q.count - CB'(1);
            if (cnt_new == '0) begin
              slot_wdata.live = 1'b0;
              out_freed_d     = 1'b1;
              if (depth_q < FB'(grht_pkg::SLOT_COUNT)) begin
                fs_push = cmd_i.update;
                depth_d = depth_q + FB'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
      slot_wdata.count = cnt_new;
      slot_we          = cmd_i.update;
      out_count_d      = cnt_new;
    end
  end

  // Slot memory: one read and one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (cmd_i.capture || cmd_i.pop) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  // Free stack memory
  always_ff @(posedge clk_i) begin
    if (fs_push) begin
      fs_mem[depth_q[SB-1:0]] <= h_idx[SB-1:0];
    end
    if (cmd_i.capture) begin
      fs_top_q <= fs_mem[fs_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= grht_pkg::kind_e'(in_kind_i);
      handle_q  <= in_data_i[HB-1:0];
      payload_q <= in_data_i[HB+PB-1:HB];
    end
    if (cmd_i.update) begin
      out_status_q  <= out_status_d;
      out_handle_q  <= out_handle_d;
      out_payload_q <= out_payload_d;
      out_count_q   <= out_count_d;
      out_freed_q   <= out_freed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      fresh_q     <= FB'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        depth_q     <= depth_d;
        fresh_q     <= fresh_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = {(grht_pkg::OUT_DATA_BITS - grht_pkg::OUT_RAW_BITS)'(0),
                         out_freed_q, out_count_q, out_payload_q, out_handle_q};

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= FB'(grht_pkg::SLOT_COUNT))
    else $error("free stack depth beyond table size");
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q != '0) && (fresh_q <= FB'(grht_pkg::SLOT_COUNT)))
    else $error("fresh slot pointer out of range");
  a_stack_bounded_by_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q < fresh_q)
    else $error("more freed slots than slots handed out");
  a_update_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> out_valid_q)
    else $error("update did not load a result");
`endif

endmodule
